### sv/kda_pkg.sv
package kda_pkg;

  localparam int KEY_COUNT = 5;
  localparam int CMD_DEPTH = 4;
  localparam int EVT_DEPTH = 4;

  localparam int KEY_POS_W = 15;
  localparam int POS_SLOTS = KEY_POS_W / 3;

  localparam int ADDR_W = 5;
  localparam int DATA_W = 32;

  localparam logic [2:0] REG_LONG_PRESS = 3'd0;
  localparam logic [2:0] REG_REPEAT     = 3'd1;
  localparam logic [2:0] REG_STREAK     = 3'd2;
  localparam logic [2:0] REG_STALE      = 3'd3;
  localparam logic [2:0] REG_KEY_POS    = 3'd4;

  localparam logic [15:0]          LONG_PRESS_RST = 16'd500;
  localparam logic [15:0]          REPEAT_RST     = 16'd100;
  localparam logic [7:0]           STREAK_RST     = 8'd3;
  localparam logic [15:0]          STALE_RST      = 16'd30;
  localparam logic [KEY_POS_W-1:0] KEY_POS_RST    = 15'd32099;

  typedef enum logic [1:0] {
    EV_DOWN   = 2'd0,
    EV_UP     = 2'd1,
    EV_REPEAT = 2'd2
  } ev_kind_t;

  typedef enum logic [1:0] {
    BK_IDLE,
    BK_EDGE,
    BK_RPT,
    BK_FLUSH
  } back_state_t;

  typedef struct packed {
    logic [15:0]          long_press_ms;
    logic [15:0]          repeat_ms;
    logic [7:0]           streak_needed;
    logic [15:0]          stale_limit_ms;
    logic [KEY_POS_W-1:0] key_bit_positions;
  } cfg_t;

  typedef struct packed {
    ev_kind_t    kind;
    logic [2:0]  key;
    logic [31:0] time_ms;
    logic        last;
  } evt_t;

endpackage

### sv/kda_fifo.sv
module kda_fifo #(
  parameter int Width = 8,
  parameter int Depth = 4
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             push,
  input  logic [Width-1:0] wdata,
  output logic             full,
  input  logic             pop,
  output logic [Width-1:0] rdata,
  output logic             empty
);

  localparam int PtrW = (Depth > 1) ? $clog2(Depth) : 1;

  logic [Width-1:0] mem [Depth];
  logic [PtrW:0]    wr_ptr;
  logic [PtrW:0]    rd_ptr;
  logic             do_push;
  logic             do_pop;

  assign empty   = (wr_ptr == rd_ptr);
  assign full    = (wr_ptr[PtrW] != rd_ptr[PtrW]) &&
                   (wr_ptr[PtrW-1:0] == rd_ptr[PtrW-1:0]);
  assign do_push = push && !full;
  assign do_pop  = pop && !empty;
  assign rdata   = mem[rd_ptr[PtrW-1:0]];

  always_ff @(posedge clk) begin
    if (rst) begin
      wr_ptr <= '0;
      rd_ptr <= '0;
    end else begin
      if (do_push) begin
        wr_ptr <= wr_ptr + 1'b1;
      end
      if (do_pop) begin
        rd_ptr <= rd_ptr + 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (do_push) begin
      mem[wr_ptr[PtrW-1:0]] <= wdata;
    end
  end

endmodule

### sv/kda_front.sv
module kda_front #(
  parameter int KeyCount = kda_pkg::KEY_COUNT
) (
  input  kda_pkg::cfg_t        cfg,
  input  logic                 accept,
  input  logic [31:0]          now_ms,
  input  logic [7:0]           sample_byte,
  input  logic [31:0]          sample_time_ms,
  output logic                 cmd_push,
  output logic [KeyCount-1:0]  cmd_pressed
);

  logic [2:0]  pos [KeyCount];
  logic [7:0]  mask;
  logic [7:0]  raw;
  logic [7:0]  low;
  logic        multi_low;
  logic [31:0] age;
  logic        stale;

  for (genvar g = 0; g < KeyCount; g++) begin : g_key
    if (g < kda_pkg::POS_SLOTS) begin : g_pos
      assign pos[g] = cfg.key_bit_positions[3*g +: 3];
    end else begin : g_zero
      assign pos[g] = 3'd0;
    end
    assign cmd_pressed[g] = ~raw[pos[g]];
  end

  always_comb begin
    mask = 8'd0;
    for (int k = 0; k < KeyCount; k++) begin
      mask = mask | (8'd1 << pos[k]);
    end
    raw       = sample_byte | ~mask;
    low       = ~raw;
    multi_low = (low & (low - 8'd1)) != 8'd0;
    age       = now_ms - sample_time_ms;
    stale     = age > {16'd0, cfg.stale_limit_ms};
    cmd_push  = accept && !stale && !multi_low;
  end

endmodule

### sv/kda_back.sv
module kda_back #(
  parameter int KeyCount = kda_pkg::KEY_COUNT
) (
  input  logic                clk,
  input  logic                rst,
  input  kda_pkg::cfg_t       cfg,
  input  logic                cmd_empty,
  input  logic [31:0]         cmd_now,
  input  logic [KeyCount-1:0] cmd_pressed,
  output logic                cmd_pop,
  input  logic                oq_full,
  output logic                oq_push,
  output kda_pkg::evt_t       oq_word
);

  localparam int KeyW = (KeyCount > 1) ? $clog2(KeyCount) : 1;
  localparam logic [KeyW-1:0] LastKey = KeyW'(KeyCount - 1);

  function automatic logic [7:0] sat_inc(input logic [7:0] v);
    sat_inc = (v == 8'hFF) ? v : v + 8'd1;
  endfunction

  kda_pkg::back_state_t state;
  kda_pkg::back_state_t state_next;
  logic [KeyW-1:0]      key;
  logic [KeyW-1:0]      key_next;

  logic [31:0]          cur_now;
  logic [KeyCount-1:0]  cur_pressed;
  logic [KeyCount-1:0]  deb;
  logic [7:0]           prun [KeyCount];
  logic [7:0]           rrun [KeyCount];
  logic [31:0]          nrt  [KeyCount];
  kda_pkg::evt_t        held;
  logic                 held_valid;

  logic [7:0]           need;
  logic [7:0]           prun_n;
  logic [7:0]           rrun_n;
  logic                 go_down;
  logic                 go_up;
  logic [31:0]          rpt_diff;
  logic                 rpt_due;
  logic                 gen_valid;
  kda_pkg::ev_kind_t    gen_kind;
  kda_pkg::evt_t        gen_word;
  logic                 need_push;
  logic                 go;

  always_comb begin
    need     = (cfg.streak_needed == 8'd0) ? 8'd1 : cfg.streak_needed;
    prun_n   = cur_pressed[key] ? sat_inc(prun[key]) : 8'd0;
    rrun_n   = cur_pressed[key] ? 8'd0 : sat_inc(rrun[key]);
    go_down  = !deb[key] && (prun_n >= need);
    go_up    = deb[key] && (rrun_n >= need);
    rpt_diff = cur_now - nrt[key];
    rpt_due  = deb[key] && !rpt_diff[31];

    gen_valid = 1'b0;
    gen_kind  = kda_pkg::EV_DOWN;
    case (state)
      kda_pkg::BK_EDGE: begin
        gen_valid = go_down || go_up;
        gen_kind  = go_down ? kda_pkg::EV_DOWN : kda_pkg::EV_UP;
      end
      kda_pkg::BK_RPT: begin
        gen_valid = rpt_due;
        gen_kind  = kda_pkg::EV_REPEAT;
      end
      default: begin
        gen_valid = 1'b0;
      end
    endcase

    gen_word.kind    = gen_kind;
    gen_word.key     = 3'(key);
    gen_word.time_ms = cur_now;
    gen_word.last    = 1'b0;

    need_push = held_valid && (gen_valid || (state == kda_pkg::BK_FLUSH));
    go        = !(need_push && oq_full);
    oq_push   = need_push && !oq_full;
    oq_word      = held;
    oq_word.last = (state == kda_pkg::BK_FLUSH);
  end

  always_comb begin
    state_next = state;
    key_next   = key;
    cmd_pop    = 1'b0;
    case (state)
      kda_pkg::BK_IDLE: begin
        if (!cmd_empty) begin
          cmd_pop    = 1'b1;
          key_next   = '0;
          state_next = kda_pkg::BK_EDGE;
        end
      end
      kda_pkg::BK_EDGE: begin
        if (go) begin
          state_next = kda_pkg::BK_RPT;
        end
      end
      kda_pkg::BK_RPT: begin
        if (go) begin
          if (key == LastKey) begin
            state_next = kda_pkg::BK_FLUSH;
          end else begin
            key_next   = key + 1'b1;
            state_next = kda_pkg::BK_EDGE;
          end
        end
      end
      kda_pkg::BK_FLUSH: begin
        if (go) begin
          state_next = kda_pkg::BK_IDLE;
        end
      end
      default: begin
        state_next = kda_pkg::BK_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= kda_pkg::BK_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      key        <= '0;
      held_valid <= 1'b0;
      deb        <= '0;
      for (int k = 0; k < KeyCount; k++) begin
        prun[k] <= 8'd0;
        rrun[k] <= 8'd0;
        nrt[k]  <= 32'd0;
      end
    end else begin
      key <= key_next;
      if (go) begin
        if (state == kda_pkg::BK_EDGE) begin
          prun[key] <= prun_n;
          rrun[key] <= rrun_n;
          if (go_down) begin
            deb[key] <= 1'b1;
            nrt[key] <= cur_now + {16'd0, cfg.long_press_ms};
          end else if (go_up) begin
            deb[key] <= 1'b0;
          end
        end
        if ((state == kda_pkg::BK_RPT) && rpt_due) begin
          nrt[key] <= cur_now + {16'd0, cfg.repeat_ms};
        end
        if (gen_valid) begin
          held_valid <= 1'b1;
        end else if (state == kda_pkg::BK_FLUSH) begin
          held_valid <= 1'b0;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd_pop) begin
      cur_now     <= cmd_now;
      cur_pressed <= cmd_pressed;
    end
    if (go && gen_valid) begin
      held <= gen_word;
    end
  end

endmodule

### sv/key_debounce_autorepeat.sv
// Path: a tick passes the command queue, the key sequencer and a hold register, then the event queue.
// Throughput: the front takes one tick per cycle while its 4-word queue has room; the key
// sequencer takes a kept tick only when idle: an edge and a repeat phase per key, then a flush,
// stalled while the event queue is full; dropped ticks (stale or several buttons low) skip it.
// Reset (rst, synchronous): queues empty, keys released, streaks and repeat times zero,
// registers back to 500, 100, 3, 30 and 32099.
module key_debounce_autorepeat #(
  parameter int KeyCount = kda_pkg::KEY_COUNT,
  parameter int CmdDepth = kda_pkg::CMD_DEPTH,
  parameter int EvtDepth = kda_pkg::EVT_DEPTH
) (
  input  logic                       clk,
  input  logic                       rst,
  input  logic                       psel,
  input  logic                       penable,
  input  logic                       pwrite,
  input  logic [kda_pkg::ADDR_W-1:0] paddr,
  input  logic [kda_pkg::DATA_W-1:0] pwdata,
  output logic [kda_pkg::DATA_W-1:0] prdata,
  output logic                       pready,
  input  logic                       push,
  output logic                       full,
  input  logic [31:0]                now_ms,
  input  logic [7:0]                 sample_byte,
  input  logic [31:0]                sample_time_ms,
  output logic                       empty,
  input  logic                       pop,
  output logic [1:0]                 event_kind,
  output logic [2:0]                 key_index,
  output logic [31:0]                event_time_ms,
  output logic                       last_of_run
);

  localparam int CmdW = 32 + KeyCount;
  localparam int EvtW = $bits(kda_pkg::evt_t);

  kda_pkg::cfg_t        cfg;
  logic [2:0]           reg_idx;
  logic                 cfg_wr;
  logic                 in_accept;
  logic                 cmd_push;
  logic [KeyCount-1:0]  front_pressed;
  logic [CmdW-1:0]      cmd_wdata;
  logic [CmdW-1:0]      cmd_rdata;
  logic                 cmd_empty;
  logic                 cmd_pop;
  logic                 oq_push;
  logic                 oq_full;
  kda_pkg::evt_t        oq_word;
  logic [EvtW-1:0]      oq_rdata;
  kda_pkg::evt_t        head;

  assign pready    = 1'b1;
  assign reg_idx   = paddr[kda_pkg::ADDR_W-1:2];
  assign cfg_wr    = psel && penable && pwrite && pready;
  assign in_accept = push && !full;

  always_ff @(posedge clk) begin
    if (rst) begin
      cfg.long_press_ms     <= kda_pkg::LONG_PRESS_RST;
      cfg.repeat_ms         <= kda_pkg::REPEAT_RST;
      cfg.streak_needed     <= kda_pkg::STREAK_RST;
      cfg.stale_limit_ms    <= kda_pkg::STALE_RST;
      cfg.key_bit_positions <= kda_pkg::KEY_POS_RST;
    end else if (cfg_wr) begin
      case (reg_idx)
        kda_pkg::REG_LONG_PRESS: cfg.long_press_ms  <= pwdata[15:0];
        kda_pkg::REG_REPEAT:     cfg.repeat_ms      <= pwdata[15:0];
        kda_pkg::REG_STREAK:     cfg.streak_needed  <= pwdata[7:0];
        kda_pkg::REG_STALE:      cfg.stale_limit_ms <= pwdata[15:0];
        kda_pkg::REG_KEY_POS: begin
          cfg.key_bit_positions <= pwdata[kda_pkg::KEY_POS_W-1:0];
        end
        default: begin
        end
      endcase
    end
  end

  always_comb begin
    case (reg_idx)
      kda_pkg::REG_LONG_PRESS: prdata = {16'd0, cfg.long_press_ms};
      kda_pkg::REG_REPEAT:     prdata = {16'd0, cfg.repeat_ms};
      kda_pkg::REG_STREAK:     prdata = {24'd0, cfg.streak_needed};
      kda_pkg::REG_STALE:      prdata = {16'd0, cfg.stale_limit_ms};
      kda_pkg::REG_KEY_POS: begin
        prdata = {{(kda_pkg::DATA_W - kda_pkg::KEY_POS_W){1'b0}}, cfg.key_bit_positions};
      end
      default:                 prdata = '0;
    endcase
  end

  kda_front #(
    .KeyCount(KeyCount)
  ) u_front (
    .cfg            (cfg),
    .accept         (in_accept),
    .now_ms         (now_ms),
    .sample_byte    (sample_byte),
    .sample_time_ms (sample_time_ms),
    .cmd_push       (cmd_push),
    .cmd_pressed    (front_pressed)
  );

  assign cmd_wdata = {now_ms, front_pressed};

  kda_fifo #(
    .Width(CmdW),
    .Depth(CmdDepth)
  ) u_cmd_q (
    .clk   (clk),
    .rst   (rst),
    .push  (cmd_push),
    .wdata (cmd_wdata),
    .full  (full),
    .pop   (cmd_pop),
    .rdata (cmd_rdata),
    .empty (cmd_empty)
  );

  kda_back #(
    .KeyCount(KeyCount)
  ) u_back (
    .clk         (clk),
    .rst         (rst),
    .cfg         (cfg),
    .cmd_empty   (cmd_empty),
    .cmd_now     (cmd_rdata[KeyCount +: 32]),
    .cmd_pressed (cmd_rdata[KeyCount-1:0]),
    .cmd_pop     (cmd_pop),
    .oq_full     (oq_full),
    .oq_push     (oq_push),
    .oq_word     (oq_word)
  );

  kda_fifo #(
    .Width(EvtW),
    .Depth(EvtDepth)
  ) u_evt_q (
    .clk   (clk),
    .rst   (rst),
    .push  (oq_push),
    .wdata (oq_word),
    .full  (oq_full),
    .pop   (pop),
    .rdata (oq_rdata),
    .empty (empty)
  );

  assign head          = kda_pkg::evt_t'(oq_rdata);
  assign event_kind    = head.kind;
  assign key_index     = head.key;
  assign event_time_ms = head.time_ms;
  assign last_of_run   = head.last;

endmodule

### bench/testbench.sv
`timescale 1ns / 1ps

module testbench;
  import kda_pkg::*;

  localparam int unsigned TIMEOUT_NS = 2_000_000;
  localparam int SETTLE_CYCLES = 100;
  localparam int PHASE_TICKS = 28;
  localparam int HOLD_OFF_LEN = 400;

  typedef enum logic [1:0] {
    POP_ALWAYS,
    POP_MOSTLY,
    POP_RARELY,
    POP_PERIODIC
  } pop_mode_t;

  logic              clk;
  logic              rst;
  logic              psel;
  logic              penable;
  logic              pwrite;
  logic [ADDR_W-1:0] paddr;
  logic [DATA_W-1:0] pwdata;
  logic [DATA_W-1:0] prdata;
  logic              pready;
  logic              push;
  logic              full;
  logic [31:0]       now_ms;
  logic [7:0]        sample_byte;
  logic [31:0]       sample_time_ms;
  logic              empty;
  logic              pop;
  logic [1:0]        event_kind;
  logic [2:0]        key_index;
  logic [31:0]       event_time_ms;
  logic              last_of_run;

  // Predicted key state and register copies
  logic [15:0] lp_ms;
  logic [15:0] rpt_ms;
  logic [7:0]  streak_cfg;
  logic [15:0] stale_cfg;
  logic [14:0] keymap;
  logic        key_down [KEY_COUNT];
  logic [7:0]  press_streak [KEY_COUNT];
  logic [7:0]  release_streak [KEY_COUNT];
  logic [31:0] repeat_due [KEY_COUNT];

  evt_t        pending_events [$];
  evt_t        want;
  int          errors = 0;
  int          ticks_sent = 0;
  int          events_checked = 0;
  int          reg_writes = 0;
  logic [31:0] clock_ms = 32'd0;
  bit          pace_on = 1'b1;
  int          burst_left = 0;
  int          hold_off_cycles = 0;
  pop_mode_t   pop_mode = POP_ALWAYS;
  int          mode_left = 0;
  int          stall_count = 0;

  key_debounce_autorepeat u_top (
    .clk            (clk),
    .rst            (rst),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready),
    .push           (push),
    .full           (full),
    .now_ms         (now_ms),
    .sample_byte    (sample_byte),
    .sample_time_ms (sample_time_ms),
    .empty          (empty),
    .pop            (pop),
    .event_kind     (event_kind),
    .key_index      (key_index),
    .event_time_ms  (event_time_ms),
    .last_of_run    (last_of_run)
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  initial begin
    #(TIMEOUT_NS);
    $display("Some tests failed");
    $finish;
  end

  function automatic logic [7:0] used_bits();
    logic [7:0] used;
    used = 8'h00;
    for (int k = 0; k < KEY_COUNT; k++) used[keymap[3*k +: 3]] = 1'b1;
    return used;
  endfunction

  function automatic logic [7:0] press_byte(input int k);
    logic [7:0] b;
    b = 8'($urandom_range(0, 255)) | used_bits();
    b[keymap[3*k +: 3]] = 1'b0;
    return b;
  endfunction

  function automatic logic [7:0] release_byte();
    return 8'($urandom_range(0, 255)) | used_bits();
  endfunction

  function automatic logic [31:0] time_step();
    int r;
    r = $urandom_range(0, 19);
    if (r == 0) return $urandom();
    if (r < 4) return $urandom_range(0, lp_ms + 2);
    return $urandom_range(0, rpt_ms / 2 + 3);
  endfunction

  function automatic void add_event(input ev_kind_t kind, input int k, input logic [31:0] t);
    evt_t ev;
    ev.kind = kind;
    ev.key = 3'(k);
    ev.time_ms = t;
    ev.last = 1'b0;
    pending_events.push_back(ev);
  endfunction

  task automatic reset_model();
    lp_ms = LONG_PRESS_RST;
    rpt_ms = REPEAT_RST;
    streak_cfg = STREAK_RST;
    stale_cfg = STALE_RST;
    keymap = KEY_POS_RST;
    for (int k = 0; k < KEY_COUNT; k++) begin
      key_down[k] = 1'b0;
      press_streak[k] = 8'd0;
      release_streak[k] = 8'd0;
      repeat_due[k] = 32'd0;
    end
  endtask

  task automatic debounce_tick(input logic [31:0] t, input logic [7:0] s,
                               input logic [31:0] st);
    logic [7:0]  level;
    logic [7:0]  need;
    logic [31:0] age;
    logic [31:0] lag;
    logic        hit;
    int          lows;
    int          first;
    evt_t        ev;
    age = t - st;
    if (age > {16'd0, stale_cfg}) return;
    level = s | ~used_bits();
    lows = 0;
    for (int b = 0; b < 8; b++) lows += int'(!level[b]);
    if (lows > 1) return;
    need = (streak_cfg == 8'd0) ? 8'd1 : streak_cfg;
    first = pending_events.size();
    for (int k = 0; k < KEY_COUNT; k++) begin
      hit = !level[keymap[3*k +: 3]];
      if (hit) begin
        if (press_streak[k] != 8'hFF) press_streak[k] = press_streak[k] + 8'd1;
        release_streak[k] = 8'd0;
      end else begin
        if (release_streak[k] != 8'hFF) release_streak[k] = release_streak[k] + 8'd1;
        press_streak[k] = 8'd0;
      end
      if (!key_down[k] && press_streak[k] >= need) begin
        key_down[k] = 1'b1;
        add_event(EV_DOWN, k, t);
        repeat_due[k] = t + {16'd0, lp_ms};
      end else if (key_down[k] && release_streak[k] >= need) begin
        key_down[k] = 1'b0;
        add_event(EV_UP, k, t);
      end
      lag = t - repeat_due[k];
      if (key_down[k] && !lag[31]) begin
        add_event(EV_REPEAT, k, t);
        repeat_due[k] = t + {16'd0, rpt_ms};
      end
    end
    if (pending_events.size() > first) begin
      ev = pending_events.pop_back();
      ev.last = 1'b1;
      pending_events.push_back(ev);
    end
  endtask

  task automatic send_tick(input logic [31:0] t, input logic [7:0] s, input logic [31:0] st);
    push <= 1'b1;
    now_ms <= t;
    sample_byte <= s;
    sample_time_ms <= st;
    @(posedge clk);
    while (full) @(posedge clk);
    ticks_sent++;
    debounce_tick(t, s, st);
    if (pace_on) begin
      if (burst_left == 0) begin
        push <= 1'b0;
        repeat ($urandom_range(1, 10)) @(posedge clk);
        burst_left = $urandom_range(1, 12);
      end else begin
        burst_left--;
      end
    end
  endtask

  task automatic poll(input logic [7:0] s);
    logic [31:0] age;
    clock_ms = clock_ms + time_step();
    age = $urandom_range(0, stale_cfg);
    send_tick(clock_ms, s, clock_ms - age);
  endtask

  task automatic wait_drain();
    push <= 1'b0;
    while (pending_events.size() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  task automatic write_reg(input logic [2:0] idx, input logic [31:0] val);
    psel <= 1'b1;
    penable <= 1'b0;
    pwrite <= 1'b1;
    paddr <= {idx, 2'b00};
    pwdata <= val;
    @(posedge clk);
    penable <= 1'b1;
    @(posedge clk);
    while (!pready) @(posedge clk);
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    @(posedge clk);
    reg_writes++;
    case (idx)
      REG_LONG_PRESS: lp_ms = val[15:0];
      REG_REPEAT:     rpt_ms = val[15:0];
      REG_STREAK:     streak_cfg = val[7:0];
      REG_STALE:      stale_cfg = val[15:0];
      REG_KEY_POS:    keymap = val[14:0];
      default: ;
    endcase
  endtask

  task automatic configure(input logic [15:0] lp, input logic [15:0] rp, input logic [7:0] sn,
                           input logic [15:0] sl, input logic [14:0] kp);
    wait_drain();
    write_reg(REG_LONG_PRESS, {16'd0, lp});
    write_reg(REG_REPEAT, {16'd0, rp});
    write_reg(REG_STREAK, {24'd0, sn});
    write_reg(REG_STALE, {16'd0, sl});
    write_reg(REG_KEY_POS, {17'd0, kp});
  endtask

  // Reset values: key 0 on bit 3, streak of three, stale limit 30 ms
  task automatic test_default_behavior();
    send_tick(32'd0, 8'hFF, 32'd0);
    send_tick(32'd1, 8'hF7, 32'd1);
    send_tick(32'd2, 8'hF7, 32'd0);
    send_tick(32'd40, 8'hF7, 32'd10);
    send_tick(32'd41, 8'hFE, 32'd10);
    send_tick(32'd45, 8'hF7, 32'd50);
    send_tick(32'd300, 8'hF7, 32'd300);
    send_tick(32'd540, 8'hF7, 32'd530);
    send_tick(32'd700, 8'hF7, 32'd700);
    send_tick(32'd701, 8'hE7, 32'd701);
    send_tick(32'd702, 8'hFF, 32'd702);
    send_tick(32'd703, 8'hFF, 32'd703);
    send_tick(32'd704, 8'hF8, 32'd704);
  endtask

  task automatic test_corner_cases();
    // all keys share bit 3, zero streak, zero delays, zero stale limit
    configure(16'd0, 16'd0, 8'd0, 16'd0, 15'h36DB);
    send_tick(32'hFFFF_FFFF, 8'hF7, 32'hFFFF_FFFF);
    send_tick(32'h0000_0000, 8'hF7, 32'h0000_0000);
    send_tick(32'd1, 8'h00, 32'd1);
    send_tick(32'd2, 8'hFF, 32'd2);
    configure(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, KEY_POS_RST);
    send_tick(32'd5, 8'h00, 32'd5);
    send_tick(32'd65540, 8'hF7, 32'd5);
    send_tick(32'd65541, 8'hF7, 32'd5);
    send_tick(32'd10, 8'hF7, 32'd11);
    wait_drain();
    write_reg(REG_STREAK, 32'd1);
    send_tick(32'd100, 8'h7F, 32'd100);
    send_tick(32'd65635, 8'h7F, 32'd65635);
    send_tick(32'd131169, 8'h7F, 32'd131169);
    send_tick(32'd131170, 8'h7F, 32'd131170);
    send_tick(32'd131171, 8'hFF, 32'd131171);
  endtask

  task automatic test_backpressure();
    configure(16'd0, 16'd0, 8'd1, 16'hFFFF, 15'd0);
    pace_on = 1'b0;
    hold_off_cycles = HOLD_OFF_LEN;
    repeat (24) poll(press_byte(0));
    wait_drain();
    pace_on = 1'b1;
  endtask

  task automatic test_random_phases();
    int          start;
    int          r;
    int          k;
    int          hold;
    int          need;
    bit          paused;
    logic [31:0] st;
    for (int p = 0; p < 6; p++) begin
      case (p)
        1: configure(16'hFFFF, 16'hFFFF, 8'hFF, 16'hFFFF, 15'h7FFF);
        2: configure(16'd0, 16'd0, 8'd1, 16'd0, 15'd0);
        default: configure(16'($urandom_range(0, 80)), 16'($urandom_range(0, 40)),
                           8'($urandom_range(0, 5)),
                           ($urandom_range(0, 3) == 0) ? 16'hFFFF : 16'($urandom_range(0, 40)),
                           15'($urandom_range(0, 32767)));
      endcase
      pace_on = (p != 0);
      clock_ms = $urandom();
      start = ticks_sent;
      paused = 1'b0;
      need = (streak_cfg == 8'd0) ? 1 : int'(streak_cfg);
      while (ticks_sent - start < PHASE_TICKS) begin
        if (p == 3 && !paused && ticks_sent - start >= PHASE_TICKS / 2) begin
          wait_drain();
          paused = 1'b1;
        end
        r = $urandom_range(0, 9);
        if (r < 7) begin
          k = $urandom_range(0, KEY_COUNT - 1);
          hold = (need > 8) ? $urandom_range(1, 8) : need + $urandom_range(0, 3);
          repeat (hold)
            poll(($urandom_range(0, 15) == 0) ? 8'($urandom_range(0, 255)) : press_byte(k));
          repeat ((need > 8) ? 2 : need + $urandom_range(0, 2)) poll(release_byte());
        end else if (r == 7) begin
          poll(8'($urandom_range(0, 255)));
        end else if (r == 8) begin
          // drop: too old, or captured after the tick
          clock_ms = clock_ms + 32'd1;
          if ($urandom_range(0, 1) == 0)
            st = clock_ms - {16'd0, stale_cfg} - 32'd1 - $urandom_range(0, 1000);
          else
            st = clock_ms + $urandom_range(1, 1000);
          send_tick(clock_ms, 8'($urandom_range(0, 255)), st);
        end else begin
          repeat ($urandom_range(1, 3)) poll(release_byte());
        end
      end
    end
  endtask

  initial begin
    pop <= 1'b0;
    forever begin
      @(posedge clk);
      if (hold_off_cycles > 0) begin
        pop <= 1'b0;
        hold_off_cycles--;
      end else begin
        if (mode_left == 0) begin
          pop_mode = pop_mode_t'($urandom_range(0, 3));
          mode_left = $urandom_range(16, 96);
        end
        mode_left--;
        stall_count++;
        case (pop_mode)
          POP_ALWAYS:  pop <= 1'b1;
          POP_MOSTLY:  pop <= ($urandom_range(0, 3) != 0);
          POP_RARELY:  pop <= ($urandom_range(0, 3) == 0);
          default:     pop <= ((stall_count % 5) < 2);
        endcase
      end
    end
  end

  always @(posedge clk) begin
    if (!rst && pop && !empty) begin
      if (pending_events.size() == 0) begin
        $error("unexpected word: kind %0d key %0d time %0d", event_kind, key_index,
               event_time_ms);
        errors++;
      end else begin
        want = pending_events.pop_front();
        events_checked++;
        if (event_kind !== want.kind) begin
          $error("event_kind: expected %0d, got %0d", want.kind, event_kind);
          errors++;
        end
        if (key_index !== want.key) begin
          $error("key_index: expected %0d, got %0d", want.key, key_index);
          errors++;
        end
        if (event_time_ms !== want.time_ms) begin
          $error("event_time_ms: expected %0d, got %0d", want.time_ms, event_time_ms);
          errors++;
        end
        if (last_of_run !== want.last) begin
          $error("last_of_run: expected %0d, got %0d", want.last, last_of_run);
          errors++;
        end
      end
    end
  end

  initial begin
    reset_model();
    rst <= 1'b1;
    psel <= 1'b0;
    penable <= 1'b0;
    pwrite <= 1'b0;
    paddr <= '0;
    pwdata <= '0;
    push <= 1'b0;
    now_ms <= 32'd0;
    sample_byte <= 8'hFF;
    sample_time_ms <= 32'd0;
    repeat (2) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);
    test_default_behavior();
    test_corner_cases();
    test_backpressure();
    test_random_phases();
    wait_drain();
    if (pending_events.size() != 0) begin
      $error("%0d events never arrived", pending_events.size());
      errors++;
    end
    $display("Covered %0d poll ticks and %0d register writes; %0d events compared.",
             ticks_sent, reg_writes, events_checked);
    if (errors == 0) begin
      $display("All tests passed");
    end else begin
      $display("Some tests failed");
    end
    $finish;
  end

endmodule
